// ----- rtl/gjc_pkg.sv -----
// shared types, codes and saturation helpers for the jacobian column core
package gjc_pkg;

  localparam int unsigned MaxJoints = 64;

  localparam logic [1:0] CfgEndPosX = 2'd0;
  localparam logic [1:0] CfgEndPosY = 2'd1;
  localparam logic [1:0] CfgEndPosZ = 2'd2;

  typedef enum logic [1:0] {
    KindRevolute   = 2'd0,
    KindContinuous = 2'd1,
    KindPrismatic  = 2'd2,
    KindFixed      = 2'd3
  } gjc_kind_e;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } gjc_adv_t;

  function automatic logic signed [15:0] sat_q2_14(input logic signed [19:0] v);
    logic signed [15:0] r;
    if (v > 20'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -20'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat_q16_16(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -36'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/gjc_axis_rot.sv -----
// rotates the local joint axis into the world frame over two stages
module gjc_axis_rot (
  input  logic                clk_i,
  input  gjc_pkg::gjc_adv_t   adv_i,
  input  logic [47:0]         rot_row_zero_i,
  input  logic [47:0]         rot_row_one_i,
  input  logic [47:0]         rot_row_two_i,
  input  logic [47:0]         local_axis_i,
  output logic signed [15:0]  w_o [3]
);

  logic [47:0]        rows [3];
  logic signed [15:0] rot_e [3][3];
  logic signed [15:0] ax_e [3];
  logic signed [31:0] prod_d [3][3];
  logic signed [31:0] prod_q [3][3];
  logic signed [33:0] acc [3];
  logic signed [33:0] shf [3];
  logic signed [15:0] w_d [3];
  logic signed [15:0] w_q [3];

  assign rows[0] = rot_row_zero_i;
  assign rows[1] = rot_row_one_i;
  assign rows[2] = rot_row_two_i;

  // stage 1: nine element products
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      ax_e[j] = $signed(local_axis_i[16*j +: 16]);
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        rot_e[i][j]  = $signed(rows[i][16*j +: 16]);
        prod_d[i][j] = rot_e[i][j] * ax_e[j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s1) begin
      prod_q <= prod_d;
    end
  end

  // stage 2: row sums, round to q2.14, saturate
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = 34'(prod_q[i][0]) + 34'(prod_q[i][1]) + 34'(prod_q[i][2]);
      shf[i] = (acc[i] + 34'sd8192) >>> 14;
      w_d[i] = gjc_pkg::sat_q2_14(shf[i][19:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s2) begin
      w_q <= w_d;
    end
  end

  assign w_o = w_q;

endmodule

// ----- rtl/gjc_cross_lin.sv -----
// lever arm, cross product and per-kind column select over four stages
module gjc_cross_lin (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gjc_pkg::gjc_adv_t   adv_i,
  input  logic signed [31:0]  end_pos_x_i,
  input  logic signed [31:0]  end_pos_y_i,
  input  logic signed [31:0]  end_pos_z_i,
  input  logic signed [31:0]  joint_pos_x_i,
  input  logic signed [31:0]  joint_pos_y_i,
  input  logic signed [31:0]  joint_pos_z_i,
  input  logic signed [15:0]  w_i [3],
  input  gjc_pkg::gjc_kind_e  kind_i,
  input  logic                col_ok_i,
  output logic signed [31:0]  lin_o [3],
  output logic signed [15:0]  ang_o [3]
);

  logic signed [32:0] r_d [3];
  logic signed [32:0] r1_q [3];
  logic signed [32:0] r2_q [3];
  logic signed [48:0] pa_d [3];
  logic signed [48:0] pb_d [3];
  logic signed [48:0] pa_q [3];
  logic signed [48:0] pb_q [3];
  logic signed [15:0] w3_q [3];
  gjc_pkg::gjc_kind_e kind3_q;
  logic               col_ok3_q;
  logic signed [49:0] diff [3];
  logic signed [49:0] shf [3];
  logic signed [31:0] lin_d [3];
  logic signed [15:0] ang_d [3];
  logic signed [31:0] lin_q [3];
  logic signed [15:0] ang_q [3];

  // stage 1: lever arm, exact 33 bits
  assign r_d[0] = 33'(end_pos_x_i) - 33'(joint_pos_x_i);
  assign r_d[1] = 33'(end_pos_y_i) - 33'(joint_pos_y_i);
  assign r_d[2] = 33'(end_pos_z_i) - 33'(joint_pos_z_i);

  always_ff @(posedge clk_i) begin
    if (adv_i.s1) begin
      r1_q <= r_d;
    end
    if (adv_i.s2) begin
      r2_q <= r1_q;
    end
  end

  // stage 3: six cross terms
  always_comb begin
    pa_d[0] = w_i[1] * r2_q[2];
    pb_d[0] = w_i[2] * r2_q[1];
    pa_d[1] = w_i[2] * r2_q[0];
    pb_d[1] = w_i[0] * r2_q[2];
    pa_d[2] = w_i[0] * r2_q[1];
    pb_d[2] = w_i[1] * r2_q[0];
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s3) begin
      pa_q      <= pa_d;
      pb_q      <= pb_d;
      w3_q      <= w_i;
      kind3_q   <= kind_i;
      col_ok3_q <= col_ok_i;
    end
  end

  // stage 4: difference, round, saturate, select by kind
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = 50'(pa_q[i]) - 50'(pb_q[i]);
      shf[i]  = (diff[i] + 50'sd8192) >>> 14;
      lin_d[i] = '0;
      ang_d[i] = '0;
      if (col_ok3_q) begin
        if (kind3_q inside {gjc_pkg::KindRevolute, gjc_pkg::KindContinuous}) begin
          lin_d[i] = gjc_pkg::sat_q16_16(shf[i][35:0]);
          ang_d[i] = w3_q[i];
        end else if (kind3_q == gjc_pkg::KindPrismatic) begin
          lin_d[i] = $signed({{14{w3_q[i][15]}}, w3_q[i], 2'b00});
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s4) begin
      lin_q <= lin_d;
      ang_q <= ang_d;
    end
  end

  assign lin_o = lin_q;
  assign ang_o = ang_q;

`ifndef SYNTHESIS
  a_lin_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv_i.s4 |=> ($stable(lin_q[0]) && $stable(lin_q[1]) && $stable(lin_q[2])))
    else $error("stalled result changed");
  a_fixed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_i.s4 && (kind3_q == gjc_pkg::KindFixed || !col_ok3_q)) |=>
      (lin_q[0] == '0 && lin_q[1] == '0 && lin_q[2] == '0 &&
       ang_q[0] == '0 && ang_q[1] == '0 && ang_q[2] == '0))
    else $error("fixed or absent column not zero");
  a_prism_ang_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_i.s4 && kind3_q == gjc_pkg::KindPrismatic) |=>
      (ang_q[0] == '0 && ang_q[1] == '0 && ang_q[2] == '0))
    else $error("prismatic column with angular part");
`endif

endmodule

// ----- rtl/geometric_jacobian_column_core.sv -----
// an accepted input is registered through stages one to four before its result is valid
// one joint column per cycle while the output is not stalled, four register stages plus ready chain
// a stalled output holds its stage; earlier stages keep filling until all are full
// reset clears all stage valid bits and sets the end-effector position to zero
// top level of the geometric jacobian column core
module geometric_jacobian_column_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [5:0]         column_index_i,
  input  logic [1:0]         joint_kind_i,
  input  logic [47:0]        rot_row_zero_i,
  input  logic [47:0]        rot_row_one_i,
  input  logic [47:0]        rot_row_two_i,
  input  logic [47:0]        local_axis_i,
  input  logic signed [31:0] joint_pos_x_i,
  input  logic signed [31:0] joint_pos_y_i,
  input  logic signed [31:0] joint_pos_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [5:0]         out_column_o,
  output logic signed [31:0] lin_x_o,
  output logic signed [31:0] lin_y_o,
  output logic signed [31:0] lin_z_o,
  output logic signed [15:0] ang_x_o,
  output logic signed [15:0] ang_y_o,
  output logic signed [15:0] ang_z_o
);

  logic signed [31:0] end_x_q, end_x_d;
  logic signed [31:0] end_y_q, end_y_d;
  logic signed [31:0] end_z_q, end_z_d;

  logic v1_q, v2_q, v3_q, v4_q;
  logic v1_d, v2_d, v3_d, v4_d;
  logic rdy1, rdy2, rdy3, rdy4;
  gjc_pkg::gjc_adv_t adv;

  logic [5:0]         col1_q, col2_q, col3_q, col4_q;
  gjc_pkg::gjc_kind_e kind1_q, kind2_q;
  logic               col_ok2;

  logic signed [15:0] w [3];
  logic signed [31:0] lin [3];
  logic signed [15:0] ang [3];

  // configuration
  assign cfg_ready_o = 1'b1;

  always_comb begin
    end_x_d = end_x_q;
    end_y_d = end_y_q;
    end_z_d = end_z_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        gjc_pkg::CfgEndPosX: end_x_d = $signed(cfg_data_i);
        gjc_pkg::CfgEndPosY: end_y_d = $signed(cfg_data_i);
        gjc_pkg::CfgEndPosZ: end_z_d = $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      end_x_q <= '0;
      end_y_q <= '0;
      end_z_q <= '0;
    end else begin
      end_x_q <= end_x_d;
      end_y_q <= end_y_d;
      end_z_q <= end_z_d;
    end
  end

  // stage advance, a stage moves when empty or when its successor moves
  assign rdy4 = !v4_q || out_ready_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign adv.s1 = rdy1;
  assign adv.s2 = rdy2;
  assign adv.s3 = rdy3;
  assign adv.s4 = rdy4;

  assign in_ready_o = rdy1;

  assign v1_d = adv.s1 ? in_valid_i : v1_q;
  assign v2_d = adv.s2 ? v1_q : v2_q;
  assign v3_d = adv.s3 ? v2_q : v3_q;
  assign v4_d = adv.s4 ? v3_q : v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
      v4_q <= v4_d;
    end
  end

  // column and kind travel alongside the data
  always_ff @(posedge clk_i) begin
    if (adv.s1) begin
      col1_q  <= column_index_i;
      kind1_q <= gjc_pkg::gjc_kind_e'(joint_kind_i);
    end
    if (adv.s2) begin
      col2_q  <= col1_q;
      kind2_q <= kind1_q;
    end
    if (adv.s3) begin
      col3_q <= col2_q;
    end
    if (adv.s4) begin
      col4_q <= col3_q;
    end
  end

  assign col_ok2 = {1'b0, col2_q} < 7'(gjc_pkg::MaxJoints);

  gjc_axis_rot u_axis_rot (
    .clk_i          (clk_i),
    .adv_i          (adv),
    .rot_row_zero_i (rot_row_zero_i),
    .rot_row_one_i  (rot_row_one_i),
    .rot_row_two_i  (rot_row_two_i),
    .local_axis_i   (local_axis_i),
    .w_o            (w)
  );

  gjc_cross_lin u_cross_lin (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (adv),
    .end_pos_x_i   (end_x_q),
    .end_pos_y_i   (end_y_q),
    .end_pos_z_i   (end_z_q),
    .joint_pos_x_i (joint_pos_x_i),
    .joint_pos_y_i (joint_pos_y_i),
    .joint_pos_z_i (joint_pos_z_i),
    .w_i           (w),
    .kind_i        (kind2_q),
    .col_ok_i      (col_ok2),
    .lin_o         (lin),
    .ang_o         (ang)
  );

  assign out_valid_o  = v4_q;
  assign out_column_o = col4_q;
  assign lin_x_o      = lin[0];
  assign lin_y_o      = lin[1];
  assign lin_z_o      = lin[2];
  assign ang_x_o      = ang[0];
  assign ang_y_o      = ang[1];
  assign ang_z_o      = ang[2];

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (v1_q && v2_q && v3_q && v4_q && !out_ready_i))
    else $error("input stalled with a free stage");
  a_out_from_stage3: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(v3_q))
    else $error("result appeared without a stage three item");
  a_stage1_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !rdy2) |=> v1_q)
    else $error("blocked stage one item lost");
`endif

endmodule
